// ===== src/ilru_pkg.sv =====
// ----------------------------------------------------------------------------
// ilru_pkg
// Shared constants, types and control/status bundles for the indexed LRU
// list engine.
// ----------------------------------------------------------------------------
package ilru_pkg;

    localparam int ENTRIES    = 1024;
    localparam int ROOT_INDEX = 0;
    localparam int ADDR_W     = $clog2(ENTRIES);
    localparam int IDX_W      = 10;
    localparam int TYPE_W     = 3;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr ROOT = t_addr'(ROOT_INDEX);
    localparam t_addr LAST = t_addr'(ENTRIES - 1);

    typedef enum logic [TYPE_W-1:0] {
        REQ_ADD_HEAD  = 3'd0,
        REQ_ADD_TAIL  = 3'd1,
        REQ_MOVE_HEAD = 3'd2,
        REQ_MOVE_TAIL = 3'd3,
        REQ_REMOVE    = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_UNLINK,
        S_SELF,
        S_LINK_A,
        S_LINK_B,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic eval;
        logic unlink;
        logic self_link;
        logic link_a;
        logic link_b;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic pass;
        logic is_add;
        logic is_remove;
    } t_dp_stat;

endpackage

// ===== src/indexed_lru_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// indexed_lru_list_engine_core
// Circular index-linked doubly linked LRU list over a fixed entry pool.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that self-links every entry;
// input stall stays high until it ends. Requests are then taken one at a
// time: one that fails its guard goes straight to the result, add runs
// link steps A and B, remove unlinks and then self-links, and move to
// head/tail unlinks and then runs link steps A and B. The prev and next link
// memories are each written at one address per cycle, so the up-to-three
// entry updates are issued in steps. The result sits in an output register,
// so the next request is accepted while the previous result waits on output stall.
module indexed_lru_list_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ilru_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [ilru_pkg::IDX_W-1:0]   i_entry_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_applied,
    output logic [ilru_pkg::IDX_W-1:0]   o_list_count,
    output logic                         o_list_empty,
    output logic [ilru_pkg::IDX_W-1:0]   o_head_index,
    output logic [ilru_pkg::IDX_W-1:0]   o_tail_index
);
    import ilru_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ilru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ilru_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .o_applied     (o_applied),
        .o_list_count  (o_list_count),
        .o_list_empty  (o_list_empty),
        .o_head_index  (o_head_index),
        .o_tail_index  (o_tail_index)
    );

endmodule

// ===== src/ilru_dp.sv =====
// ----------------------------------------------------------------------------
// ilru_dp
// Link memories, root head/tail registers, entry count, guard evaluation and
// the result register.
// ----------------------------------------------------------------------------
module ilru_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ilru_pkg::t_dp_cmd            i_cmd,
    output ilru_pkg::t_dp_stat           o_stat,
    input  logic [ilru_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [ilru_pkg::IDX_W-1:0]   i_entry_index,
    output logic                         o_applied,
    output logic [ilru_pkg::IDX_W-1:0]   o_list_count,
    output logic                         o_list_empty,
    output logic [ilru_pkg::IDX_W-1:0]   o_head_index,
    output logic [ilru_pkg::IDX_W-1:0]   o_tail_index
);
    import ilru_pkg::*;

    t_addr r_prev_mem [ENTRIES];
    t_addr r_next_mem [ENTRIES];

    t_addr              r_rd_prev;
    t_addr              r_rd_next;
    t_addr              r_e;
    t_addr              r_lp;
    t_addr              r_head;
    t_addr              r_tail;
    t_addr              r_clr_addr;
    t_req               r_type;
    logic               r_e_ok;
    logic               r_applied;
    logic [IDX_W-1:0]   r_count;

    logic               r_out_applied;
    logic [IDX_W-1:0]   r_out_count;
    logic               r_out_empty;
    logic [IDX_W-1:0]   r_out_head;
    logic [IDX_W-1:0]   r_out_tail;

    t_addr  in_addr;
    logic   head_op;
    t_addr  nn;
    t_addr  pp;
    logic   not_root;
    logic   is_free;
    logic   is_linked;
    logic   guard;

    logic   prev_we;
    t_addr  prev_wa;
    t_addr  prev_wd;
    logic   next_we;
    t_addr  next_wa;
    t_addr  next_wd;

    assign in_addr = t_addr'(i_entry_index);

    // neighbors for the insert: between root and head, or between tail and root
    assign head_op = (r_type == REQ_ADD_HEAD) || (r_type == REQ_MOVE_HEAD);
    assign nn      = head_op ? r_head : ROOT;
    assign pp      = head_op ? ROOT : r_tail;

    assign not_root  = (r_e != ROOT);
    assign is_free   = not_root && (r_rd_next == r_e) && (r_rd_prev == r_e);
    assign is_linked = not_root && (r_rd_next != r_e) && (r_rd_prev != r_e);

    always_comb begin
        case (r_type)
            REQ_ADD_HEAD,
            REQ_ADD_TAIL:  guard = is_free;
            REQ_MOVE_HEAD: guard = is_linked && (r_rd_prev != ROOT) && (r_rd_next != r_rd_prev);
            REQ_MOVE_TAIL: guard = is_linked && (r_rd_next != ROOT) && (r_rd_next != r_rd_prev);
            REQ_REMOVE:    guard = is_linked;
            default:       guard = 1'b0;
        endcase
    end

    assign o_stat.clr_last  = (r_clr_addr == LAST);
    assign o_stat.pass      = r_e_ok && guard;
    assign o_stat.is_add    = (r_type == REQ_ADD_HEAD) || (r_type == REQ_ADD_TAIL);
    assign o_stat.is_remove = (r_type == REQ_REMOVE);

    // One write per link memory per cycle; root links live in r_head/r_tail.
    always_comb begin
        prev_we = 1'b0;
        prev_wa = r_e;
        prev_wd = r_e;
        next_we = 1'b0;
        next_wa = r_e;
        next_wd = r_e;
        if (i_cmd.clr_wr) begin
            prev_we = 1'b1;
            prev_wa = r_clr_addr;
            prev_wd = r_clr_addr;
            next_we = 1'b1;
            next_wa = r_clr_addr;
            next_wd = r_clr_addr;
        end else if (i_cmd.unlink) begin
            prev_we = (r_rd_next != ROOT);
            prev_wa = r_rd_next;
            prev_wd = r_rd_prev;
            next_we = (r_rd_prev != ROOT);
            next_wa = r_rd_prev;
            next_wd = r_rd_next;
        end else if (i_cmd.self_link) begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end else if (i_cmd.link_a) begin
            prev_we = (nn != ROOT);
            prev_wa = nn;
            prev_wd = r_e;
            next_we = 1'b1;
            next_wa = r_e;
            next_wd = nn;
        end else if (i_cmd.link_b) begin
            prev_we = 1'b1;
            prev_wa = r_e;
            prev_wd = r_lp;
            next_we = (r_lp != ROOT);
            next_wa = r_lp;
            next_wd = r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (i_cmd.accept) begin
            r_rd_prev <= r_prev_mem[in_addr];
            r_rd_next <= r_next_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= ROOT;
            r_tail     <= ROOT;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= t_addr'(r_clr_addr + 1'b1);
            end
            if (i_cmd.unlink) begin
                if (r_rd_next == ROOT) begin
                    r_tail <= r_rd_prev;
                end
                if (r_rd_prev == ROOT) begin
                    r_head <= r_rd_next;
                end
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.link_a) begin
                if (nn == ROOT) begin
                    r_tail <= r_e;
                end
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.link_b && (r_lp == ROOT)) begin
                r_head <= r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_e    <= in_addr;
            r_type <= t_req'(i_req_type);
            r_e_ok <= (32'(i_entry_index) < 32'(ENTRIES));
        end
        if (i_cmd.eval) begin
            r_applied <= o_stat.pass;
        end
        if (i_cmd.link_a) begin
            r_lp <= pp;
        end
        if (i_cmd.out_load) begin
            r_out_applied <= r_applied;
            r_out_count   <= r_count;
            r_out_empty   <= (r_head == ROOT);
            r_out_head    <= IDX_W'(r_head);
            r_out_tail    <= IDX_W'(r_tail);
        end
    end

    assign o_applied    = r_out_applied;
    assign o_list_count = r_out_count;
    assign o_list_empty = r_out_empty;
    assign o_head_index = r_out_head;
    assign o_tail_index = r_out_tail;

endmodule

// ===== src/ilru_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilru_ctrl
// Request sequencer: clearing pass after reset, guard check, link update
// steps and the result handshake.
// ----------------------------------------------------------------------------
module ilru_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ilru_pkg::t_dp_stat  i_stat,
    output ilru_pkg::t_dp_cmd   o_cmd
);
    import ilru_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_stat.pass) begin
                    n_state = S_DONE;
                end else if (i_stat.is_add) begin
                    n_state = S_LINK_A;
                end else begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = i_stat.is_remove ? S_SELF : S_LINK_A;
            end
            S_SELF: begin
                o_cmd.self_link = 1'b1;
                n_state         = S_DONE;
            end
            S_LINK_A: begin
                o_cmd.link_a = 1'b1;
                n_state      = S_LINK_B;
            end
            S_LINK_B: begin
                o_cmd.link_b = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/ilru_chk.sv =====
// ----------------------------------------------------------------------------
// ilru_chk
// Port-level checks for the LRU list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ilru_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [ilru_pkg::TYPE_W-1:0]  i_req_type,
    input logic [ilru_pkg::IDX_W-1:0]   i_entry_index,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_applied,
    input logic [ilru_pkg::IDX_W-1:0]   o_list_count,
    input logic                         o_list_empty,
    input logic [ilru_pkg::IDX_W-1:0]   o_head_index,
    input logic [ilru_pkg::IDX_W-1:0]   o_tail_index
);

    // empty flag agrees with the root head link
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_list_empty == (o_head_index == '0)))
        else $error("empty flag disagrees with head index");

    // head and tail are both root or both real entries
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_head_index == '0) == (o_tail_index == '0)))
        else $error("head and tail disagree on emptiness");

    // count tracks emptiness
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_list_empty == (o_list_count == '0)))
        else $error("list count disagrees with empty flag");

    // one request at a time: an input beat is followed by stall
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_applied)
            && $stable(o_list_count) && $stable(o_list_empty)
            && $stable(o_head_index) && $stable(o_tail_index)))
        else $error("stalled result changed");

endmodule

bind indexed_lru_list_engine_core ilru_chk u_ilru_chk (.*);
